// File: sv/cac_pkg.sv
// Shared types and constants for the checked accumulator calculator.
// No dependencies; imported by every other file in sv/.
package cac_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int TDATA_W    = ((DATA_WIDTH + 3 + 7) / 8) * 8;
  localparam int IN_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  typedef logic [DATA_WIDTH-1:0]   word_t;
  typedef logic [2*DATA_WIDTH-1:0] dword_t;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MOD = 3'd4,
    CMD_NEG = 3'd5,
    CMD_POW = 3'd6,
    CMD_CLR = 3'd7
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_POW  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

// File: sv/cac_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on cac_pkg.
module cac_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  cac_pkg::word_t op_a,
  input  cac_pkg::word_t op_b,
  output logic           done,
  output cac_pkg::dword_t product
);
  import cac_pkg::*;

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  word_t            a_r, hi_r, lo_r;
  logic [DATA_WIDTH:0] sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= op_a;
      hi_r <= '0;
      lo_r <= op_b;
    end else if (busy_r) begin
      hi_r <= sum[DATA_WIDTH:1];
      lo_r <= {sum[0], lo_r[DATA_WIDTH-1:1]};
    end
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};

endmodule

// File: sv/cac_div.sv
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on cac_pkg.
module cac_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  cac_pkg::word_t dividend,
  input  cac_pkg::word_t divisor,
  output logic           done,
  output cac_pkg::word_t quotient,
  output cac_pkg::word_t remainder
);
  import cac_pkg::*;

  logic                busy_r, done_r;
  logic [CNT_W-1:0]    cnt_r;
  word_t               d_r, rem_r, quo_r;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  fits;

  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d_r};
  assign fits    = !diff[DATA_WIDTH+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_r <= {quo_r[DATA_WIDTH-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: sv/checked_accumulator_calculator.sv
// Checked accumulator calculator: top level with command sequencer and result register.
// Depends on cac_pkg, cac_mul and cac_div.
//
// Each input beat applies one command to the 32-bit signed running total and yields one
// result beat. Add, subtract, negate, clear, division by zero and power with an exponent
// of zero or less go straight to the done state; multiply, divide and modulus wait in
// S_MUL or S_DIV for the bit-serial multiplier or divider (one bit per cycle); power
// runs one round per significant exponent bit in S_POW, running a multiply and a
// square side by side in two serial multipliers each round. One item is in work at a
// time; a finished result waits in the output register while the next beat is taken.
module checked_accumulator_calculator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cac_pkg::IN_TDATA_W-1:0] in_tdata,  // [31:0] operand
  input  logic [2:0]                     in_tuser,  // [2:0] command
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cac_pkg::TDATA_W-1:0]    out_tdata  // [31:0] total, [32] overflow,
                                                    // [33] underflow, [34] divide_by_zero
);
  import cac_pkg::*;

  state_t state_r, state_nxt;
  word_t  total_r, total_nxt;
  logic   ov_r, ov_nxt, un_r, un_nxt, dz_r, dz_nxt;
  logic   neg_r, neg_nxt, is_mod_r, is_mod_nxt;
  word_t  acc_r, acc_nxt, base_r, base_nxt, exp_r, exp_nxt;
  logic   acc_huge_r, acc_huge_nxt, base_huge_r, base_huge_nxt;
  logic   pow_go_r, pow_go_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic [TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic   accept;
  cmd_t   cmd;
  word_t  a, b, ua, ub, sum, dif, neg_a, mag;
  logic   sa, sb, mul_start, div_start;
  word_t  m0_a, m0_b;
  logic   m0_done, m1_done, d_done;
  dword_t m0_p, m1_p;
  word_t  d_q, d_rem;

  assign cmd    = cmd_t'(in_tuser);
  assign a      = total_r;
  assign b      = in_tdata[DATA_WIDTH-1:0];
  assign sa     = a[DATA_WIDTH-1];
  assign sb     = b[DATA_WIDTH-1];
  assign neg_a  = '0 - a;
  assign ua     = sa ? neg_a : a;
  assign ub     = sb ? ('0 - b) : b;
  assign sum    = a + b;
  assign dif    = a - b;
  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready;

  assign mul_start = (accept && cmd == CMD_MUL) || pow_go_r;
  assign div_start = accept && (cmd == CMD_DIV || cmd == CMD_MOD) && (ub != '0);
  assign m0_a = (state_r == S_POW) ? acc_r  : ua;
  assign m0_b = (state_r == S_POW) ? base_r : ub;

  cac_mul u_mul_acc (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .op_a(m0_a), .op_b(m0_b),
    .done(m0_done), .product(m0_p)
  );

  cac_mul u_mul_sq (
    .clk(clk), .rst_n(rst_n), .start(pow_go_r), .op_a(base_r), .op_b(base_r),
    .done(m1_done), .product(m1_p)
  );

  cac_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(ua), .divisor(ub),
    .done(d_done), .quotient(d_q), .remainder(d_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    ov_nxt        = ov_r;
    un_nxt        = un_r;
    dz_nxt        = dz_r;
    neg_nxt       = neg_r;
    is_mod_nxt    = is_mod_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    acc_huge_nxt  = acc_huge_r;
    base_huge_nxt = base_huge_r;
    pow_go_nxt    = 1'b0;
    mag           = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ov_nxt     = 1'b0;
          un_nxt     = 1'b0;
          dz_nxt     = 1'b0;
          neg_nxt    = sa ^ sb;
          is_mod_nxt = (cmd == CMD_MOD);
          state_nxt  = S_DONE;
          case (cmd)
            CMD_ADD: begin
              total_nxt = sum;
              ov_nxt    = !sa && !sb && sum[DATA_WIDTH-1];
              un_nxt    = sa && sb && !sum[DATA_WIDTH-1];
            end
            CMD_SUB: begin
              total_nxt = dif;
              ov_nxt    = !sa && sb && dif[DATA_WIDTH-1];
              un_nxt    = sa && !sb && !dif[DATA_WIDTH-1];
            end
            CMD_MUL: state_nxt = S_MUL;
            CMD_DIV, CMD_MOD: begin
              if (ub == '0) dz_nxt = 1'b1;
              else state_nxt = S_DIV;
            end
            CMD_NEG: begin
              total_nxt = neg_a;
              ov_nxt    = (a == {1'b1, {(DATA_WIDTH-1){1'b0}}});
            end
            CMD_POW: begin
              if (sb || b == '0) begin
                total_nxt = word_t'(1);
              end else begin
                neg_nxt       = sa && b[0];
                acc_nxt       = word_t'(1);
                base_nxt      = ua;
                exp_nxt       = b;
                acc_huge_nxt  = 1'b0;
                base_huge_nxt = 1'b0;
                pow_go_nxt    = 1'b1;
                state_nxt     = S_POW;
              end
            end
            CMD_CLR: total_nxt = '0;
            default: total_nxt = '0;
          endcase
        end
      end
      S_MUL: begin
        if (m0_done) begin
          mag       = m0_p[DATA_WIDTH-1:0];
          total_nxt = neg_r ? ('0 - mag) : mag;
          if (neg_r) begin
            un_nxt = (m0_p[2*DATA_WIDTH-1:DATA_WIDTH] != '0)
                  || (mag > {1'b1, {(DATA_WIDTH-1){1'b0}}});
          end else begin
            ov_nxt = (m0_p[2*DATA_WIDTH-1:DATA_WIDTH] != '0) || mag[DATA_WIDTH-1];
          end
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (d_done) begin
          if (is_mod_r) begin
            total_nxt = d_rem;
          end else begin
            total_nxt = neg_r ? ('0 - d_q) : d_q;
            ov_nxt    = !neg_r && d_q[DATA_WIDTH-1];
          end
          state_nxt = S_DONE;
        end
      end
      S_POW: begin
        if (m0_done && m1_done) begin
          if (exp_r[0]) begin
            acc_nxt      = m0_p[DATA_WIDTH-1:0];
            acc_huge_nxt = acc_huge_r || base_huge_r
                        || (m0_p[2*DATA_WIDTH-1:DATA_WIDTH] != '0);
          end
          base_nxt      = m1_p[DATA_WIDTH-1:0];
          base_huge_nxt = base_huge_r || (m1_p[2*DATA_WIDTH-1:DATA_WIDTH] != '0);
          exp_nxt       = exp_r >> 1;
          if (exp_r[DATA_WIDTH-1:1] == '0) begin
            total_nxt = neg_r ? ('0 - acc_nxt) : acc_nxt;
            if (neg_r) begin
              un_nxt = acc_huge_nxt || (acc_nxt > {1'b1, {(DATA_WIDTH-1){1'b0}}});
            end else begin
              ov_nxt = acc_huge_nxt || acc_nxt[DATA_WIDTH-1];
            end
            state_nxt = S_DONE;
          end else begin
            pow_go_nxt = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = TDATA_W'({dz_r, un_r, ov_r, total_r});
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      pow_go_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      pow_go_r     <= pow_go_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ov_r        <= ov_nxt;
    un_r        <= un_nxt;
    dz_r        <= dz_nxt;
    neg_r       <= neg_nxt;
    is_mod_r    <= is_mod_nxt;
    acc_r       <= acc_nxt;
    base_r      <= base_nxt;
    exp_r       <= exp_nxt;
    acc_huge_r  <= acc_huge_nxt;
    base_huge_r <= base_huge_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready) else $error("input taken twice for one item");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid_r || out_tready) && out_tvalid_nxt |-> state_r == S_DONE)
    else $error("result beat loaded outside done state");
  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && dz_r |-> !ov_r && !un_r)
    else $error("range flag with divide by zero");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> !(ov_r && un_r)) else $error("overflow and underflow both set");
  a_pow_units_sync: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POW |-> m0_done == m1_done) else $error("power multipliers out of step");
`endif

endmodule
